FILE: rtl/core/cwpo_pkg.sv
// ----------------------------------------------------------------------------
// Crossfade wavetable oscillator package
// Shared codes, widths, state encoding and the controller command bundle.
// ----------------------------------------------------------------------------
package cwpo_pkg;

   // Payload and register widths
   localparam int FUNC_W   = 3;
   localparam int ADDR_W   = 10;
   localparam int SMP_W    = 16;
   localparam int PITCH_W  = 17;
   localparam int BASE_W   = 27;
   localparam int WFRAC_W  = 17;
   localparam int NCYC_W   = 16;
   localparam int INC_W    = 29;
   localparam int CSR_IX_W = 2;
   localparam int CSR_D_W  = 27;

   // Item function codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK        = 3'd0,
      FUNC_WRITE_A     = 3'd1,
      FUNC_WRITE_B     = 3'd2,
      FUNC_START       = 3'd3,
      FUNC_MUTE        = 3'd4,
      FUNC_PHASE_RESET = 3'd5
   } func_type;

   // Configuration register indexes
   typedef enum logic [CSR_IX_W-1:0] {
      CSR_BASE_INCREMENT = 2'd0,
      CSR_WAVE_FRACTION  = 2'd1,
      CSR_NUM_CYCLES     = 2'd2
   } csr_index_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_LO,
      ST_RD_HI,
      ST_MUL,
      ST_MIX,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic take;       // transaction accepted this cycle
      logic reply_now;  // non-tick transaction answers at once
      logic rd_lo;      // table read address is the lower entry
      logic cap_lo;     // capture lower entry read data
      logic cap_prod;   // capture interpolation and increment products
      logic cap_mix;    // capture crossfade products
      logic commit;     // update state and load the tick result
   } ctl_cmd_type;

endpackage

FILE: rtl/core/cwpo_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cwpo_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/cwpo_ctrl.sv
// ----------------------------------------------------------------------------
// Oscillator controller
// Sequences table reads, multiply stages and the result hand-off for a tick.
// ----------------------------------------------------------------------------
module cwpo_ctrl
   import cwpo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [FUNC_W-1:0] req_func,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ctl_cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new transaction when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && out_free && (req_func == FUNC_TICK)) begin
               state_in = ST_RD_LO;
            end
         end
         ST_RD_LO: state_in = ST_RD_HI;
         ST_RD_HI: state_in = ST_MUL;
         ST_MUL:   state_in = ST_MIX;
         ST_MIX:   state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall     = !out_free;
            cmd.take      = req_valid && out_free;
            cmd.reply_now = req_valid && out_free && (req_func != FUNC_TICK);
         end
         ST_RD_LO: cmd.rd_lo    = 1'b1;
         ST_RD_HI: cmd.cap_lo   = 1'b1;
         ST_MUL:   cmd.cap_prod = 1'b1;
         ST_MIX:   cmd.cap_mix  = 1'b1;
         ST_OUT:   cmd.commit   = out_free;
         default:  cmd = '0;
      endcase
   end

   // Result valid flag.
   assign rsp_valid_in = (cmd.reply_now || cmd.commit) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/core/cwpo_dp.sv
// ----------------------------------------------------------------------------
// Oscillator datapath
// Wave tables, phase accumulator, interpolation, crossfade and cycle counting.
// ----------------------------------------------------------------------------
module cwpo_dp
   import cwpo_pkg::*;
#(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctl_cmd_type               cmd,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic [ADDR_W-1:0]         req_table_addr,
   input  logic signed [SMP_W-1:0]   req_table_value,
   input  logic signed [PITCH_W-1:0] req_pitch_offset,
   input  logic                      csr_write_enable,
   input  logic [CSR_IX_W-1:0]       csr_index,
   input  logic [CSR_D_W-1:0]        csr_write_data,
   output logic signed [SMP_W-1:0]   rsp_sample,
   output logic                      rsp_free,
   output logic                      rsp_wrapped
);

   localparam int IDX_W   = $clog2(TABLE_SIZE);
   localparam int IW      = $clog2(TABLE_SIZE + 1);
   localparam int PHASE_W = IW + 16;
   localparam int SUM_W   = ((PHASE_W > INC_W) ? PHASE_W : INC_W) + 1;
   localparam logic [SUM_W-1:0] PHASE_END = SUM_W'(TABLE_SIZE) << 16;

   // Control state
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [INC_W-1:0]   incr_ff, incr_in;
   logic [NCYC_W-1:0]  cycles_left_ff, cycles_left_in;
   logic               free_ff, free_in;
   logic               sounding_ff, sounding_in;
   logic [BASE_W-1:0]  base_inc_ff, base_inc_in;
   logic [WFRAC_W-1:0] wave_frac_ff, wave_frac_in;
   logic [NCYC_W-1:0]  num_cycles_ff, num_cycles_in;

   // Pipeline payload
   logic signed [PITCH_W-1:0] poff_ff;
   logic signed [SMP_W-1:0]   v0a_ff, v0b_ff;
   logic signed [33:0]        prod_a_ff, prod_b_ff, prod_a_in, prod_b_in;
   logic [43:0]               inc_prod_ff, inc_prod_in;
   logic signed [34:0]        mix_a_ff, mix_b_ff, mix_a_in, mix_b_in;
   logic signed [SMP_W-1:0]   rsp_sample_ff;
   logic                      rsp_free_ff, rsp_wrapped_ff;

   // Table access
   logic [IW-1:0]           i0_raw, i0w, i1_raw, i1w;
   logic [IDX_W-1:0]        rd_addr, wr_addr;
   logic                    addr_ok, we_a, we_b;
   logic signed [SMP_W-1:0] rd_a, rd_b;

   // Arithmetic
   logic signed [16:0] frac_s, diff_a, diff_b;
   logic signed [17:0] ratio_s;
   logic [16:0]        ratio_u;
   logic signed [33:0] rnd_a, rnd_b;
   logic signed [16:0] a_val, b_val;
   logic [WFRAC_W-1:0] w_sat, w_inv;
   logic signed [17:0] w_s, w_inv_s;
   logic signed [35:0] mix_sum, s_full;
   logic signed [SMP_W-1:0] s_sat;
   logic [29:0]        inc_shift;
   logic [INC_W-1:0]   inc_new;
   logic [SUM_W-1:0]   phase_sum;
   logic               wrap;

   // Table write decode; addresses beyond the table are dropped.
   assign addr_ok = 32'(req_table_addr) < 32'(TABLE_SIZE);
   assign wr_addr = IDX_W'(req_table_addr);
   assign we_a    = cmd.take && (req_func == FUNC_WRITE_A) && addr_ok;
   assign we_b    = cmd.take && (req_func == FUNC_WRITE_B) && addr_ok;

   // Read indexes wrap so that the entry past the end reads entry zero.
   assign i0_raw  = phase_ff[PHASE_W-1:16];
   assign i0w     = (i0_raw == IW'(TABLE_SIZE)) ? '0 : i0_raw;
   assign i1_raw  = i0w + 1'b1;
   assign i1w     = (i1_raw == IW'(TABLE_SIZE)) ? '0 : i1_raw;
   assign rd_addr = cmd.rd_lo ? IDX_W'(i0w) : IDX_W'(i1w);

   cwpo_ram #(.WIDTH(SMP_W), .DEPTH(TABLE_SIZE)) u_table_a (
      .clock   (clock),
      .wr_en   (we_a),
      .wr_addr (wr_addr),
      .wr_data (req_table_value),
      .rd_addr (rd_addr),
      .rd_data (rd_a)
   );

   cwpo_ram #(.WIDTH(SMP_W), .DEPTH(TABLE_SIZE)) u_table_b (
      .clock   (clock),
      .wr_en   (we_b),
      .wr_addr (wr_addr),
      .wr_data (req_table_value),
      .rd_addr (rd_addr),
      .rd_data (rd_b)
   );

   // Interpolation products: upper entry arrives while the lower one is held.
   assign frac_s    = $signed({1'b0, phase_ff[15:0]});
   assign diff_a    = $signed({rd_a[SMP_W-1], rd_a}) - $signed({v0a_ff[SMP_W-1], v0a_ff});
   assign diff_b    = $signed({rd_b[SMP_W-1], rd_b}) - $signed({v0b_ff[SMP_W-1], v0b_ff});
   assign prod_a_in = diff_a * frac_s;
   assign prod_b_in = diff_b * frac_s;

   // New increment product; a negative ratio counts as zero.
   assign ratio_s     = 18'sd16384 + $signed({poff_ff[PITCH_W-1], poff_ff});
   assign ratio_u     = ratio_s[17] ? '0 : ratio_s[16:0];
   assign inc_prod_in = base_inc_ff * ratio_u;

   // Rounded interpolation, then crossfade products with the weight capped at one.
   assign rnd_a    = (prod_a_ff + 34'sd32768) >>> 16;
   assign rnd_b    = (prod_b_ff + 34'sd32768) >>> 16;
   assign a_val    = $signed({v0a_ff[SMP_W-1], v0a_ff}) + $signed(rnd_a[16:0]);
   assign b_val    = $signed({v0b_ff[SMP_W-1], v0b_ff}) + $signed(rnd_b[16:0]);
   assign w_sat    = (wave_frac_ff > 17'd65536) ? 17'd65536 : wave_frac_ff;
   assign w_inv    = 17'd65536 - w_sat;
   assign w_s      = $signed({1'b0, w_sat});
   assign w_inv_s  = $signed({1'b0, w_inv});
   assign mix_a_in = a_val * w_inv_s;
   assign mix_b_in = b_val * w_s;

   // Final rounding and saturation of the mixed sample.
   assign mix_sum = mix_a_ff + mix_b_ff;
   assign s_full  = (mix_sum + 36'sd32768) >>> 16;
   always_comb begin
      if (s_full > 36'sd32767) begin
         s_sat = 16'sh7FFF;
      end else if (s_full < -36'sd32768) begin
         s_sat = -16'sh8000;
      end else begin
         s_sat = $signed(s_full[SMP_W-1:0]);
      end
   end

   // Increment saturates at its full width.
   assign inc_shift = inc_prod_ff[43:14];
   assign inc_new   = inc_shift[29] ? '1 : inc_shift[INC_W-1:0];

   // Phase advance and end-of-table detection.
   assign phase_sum = SUM_W'(phase_ff) + SUM_W'(incr_ff);
   assign wrap      = phase_sum > PHASE_END;

   // State update for transactions, tick commits and register writes.
   always_comb begin
      phase_in       = phase_ff;
      incr_in        = incr_ff;
      cycles_left_in = cycles_left_ff;
      free_in        = free_ff;
      sounding_in    = sounding_ff;
      base_inc_in    = base_inc_ff;
      wave_frac_in   = wave_frac_ff;
      num_cycles_in  = num_cycles_ff;

      if (cmd.take) begin
         case (req_func)
            FUNC_START: begin
               sounding_in = 1'b1;
               free_in     = 1'b0;
            end
            FUNC_MUTE:        sounding_in = 1'b0;
            FUNC_PHASE_RESET: phase_in    = '0;
            default:          ;
         endcase
      end

      if (cmd.commit) begin
         incr_in = inc_new;
         if (wrap) begin
            phase_in = '0;
            if (cycles_left_ff <= 16'd1) begin
               free_in        = 1'b1;
               cycles_left_in = num_cycles_ff;
            end else begin
               cycles_left_in = cycles_left_ff - 1'b1;
            end
         end else begin
            phase_in = PHASE_W'(phase_sum);
         end
      end

      if (csr_write_enable) begin
         case (csr_index)
            CSR_BASE_INCREMENT: base_inc_in  = csr_write_data[BASE_W-1:0];
            CSR_WAVE_FRACTION:  wave_frac_in = csr_write_data[WFRAC_W-1:0];
            CSR_NUM_CYCLES: begin
               num_cycles_in  = csr_write_data[NCYC_W-1:0];
               cycles_left_in = csr_write_data[NCYC_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= '0;
         incr_ff        <= '0;
         cycles_left_ff <= 16'd1;
         free_ff        <= 1'b0;
         sounding_ff    <= 1'b0;
         base_inc_ff    <= '0;
         wave_frac_ff   <= '0;
         num_cycles_ff  <= 16'd1;
      end else begin
         phase_ff       <= phase_in;
         incr_ff        <= incr_in;
         cycles_left_ff <= cycles_left_in;
         free_ff        <= free_in;
         sounding_ff    <= sounding_in;
         base_inc_ff    <= base_inc_in;
         wave_frac_ff   <= wave_frac_in;
         num_cycles_ff  <= num_cycles_in;
      end
   end

   // Pipeline payload and result register.
   always_ff @(posedge clock) begin
      if (cmd.take && (req_func == FUNC_TICK)) begin
         poff_ff <= req_pitch_offset;
      end
      if (cmd.cap_lo) begin
         v0a_ff <= rd_a;
         v0b_ff <= rd_b;
      end
      if (cmd.cap_prod) begin
         prod_a_ff   <= prod_a_in;
         prod_b_ff   <= prod_b_in;
         inc_prod_ff <= inc_prod_in;
      end
      if (cmd.cap_mix) begin
         mix_a_ff <= mix_a_in;
         mix_b_ff <= mix_b_in;
      end
      if (cmd.reply_now) begin
         rsp_sample_ff  <= '0;
         rsp_free_ff    <= free_in;
         rsp_wrapped_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_sample_ff  <= sounding_ff ? s_sat : '0;
         rsp_free_ff    <= free_in;
         rsp_wrapped_ff <= wrap;
      end
   end

   assign rsp_sample  = rsp_sample_ff;
   assign rsp_free    = rsp_free_ff;
   assign rsp_wrapped = rsp_wrapped_ff;

endmodule

FILE: rtl/core/crossfade_wavetable_pulse_oscillator_unit.sv
// A tick's result is loaded at its commit; any other transaction answers in the
// cycle after. A tick holds off the next transaction through the accept cycle,
// two reads through each table's single read port, the interpolation and
// crossfade multiply stages and the commit; other transactions go one per cycle
// unless a result is stalled. Reset zeroes phase, increment, flags and registers,
// sets the pass count and its counter to one and leaves the tables unwritten.
// ----------------------------------------------------------------------------
// Crossfade wavetable pulse oscillator unit
// Two-table wavetable oscillator with linear interpolation, crossfade and a
// pass counter that flags free.
// ----------------------------------------------------------------------------
module crossfade_wavetable_pulse_oscillator_unit
   import cwpo_pkg::*;
#(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic [ADDR_W-1:0]         req_table_addr,
   input  logic signed [SMP_W-1:0]   req_table_value,
   input  logic signed [PITCH_W-1:0] req_pitch_offset,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [SMP_W-1:0]   rsp_sample,
   output logic                      rsp_free,
   output logic                      rsp_wrapped,
   input  logic                      csr_write_enable,
   input  logic [CSR_IX_W-1:0]       csr_index,
   input  logic [CSR_D_W-1:0]        csr_write_data
);

   ctl_cmd_type cmd;

   // Sequencing.
   cwpo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Tables and arithmetic.
   cwpo_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_func         (req_func),
      .req_table_addr   (req_table_addr),
      .req_table_value  (req_table_value),
      .req_pitch_offset (req_pitch_offset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_sample       (rsp_sample),
      .rsp_free         (rsp_free),
      .rsp_wrapped      (rsp_wrapped)
   );

   // A transaction is never taken while a result waits stalled.
   a_no_take_when_blocked : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !(rsp_valid && rsp_stall))
      else $error("transaction accepted while result stalled");

   // A non-tick transaction answers in the next cycle.
   a_quick_reply : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_func != FUNC_TICK)) |=> rsp_valid)
      else $error("non-tick transaction gave no result");

   // A tick commit never coincides with accepting a new transaction.
   a_take_commit_exclusive : assert property (@(posedge clock) disable iff (reset)
      !(cmd.take && cmd.commit))
      else $error("accept and commit in the same cycle");

   // Only a tick result can report a wrap.
   a_wrap_only_on_tick : assert property (@(posedge clock) disable iff (reset)
      cmd.reply_now |=> !rsp_wrapped)
      else $error("wrap reported on a non-tick result");

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Crossfade wavetable oscillator testbench
// Loads both tables and sends ticks, start, mute, phase resets and spare codes
// through the request channel under random gaps and back-pressure. A
// behavioural copy of the oscillator predicts every response, and each field
// of each response is checked against it in order.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import cwpo_pkg::*;

   localparam int TABLE_DEPTH = 1024;
   localparam longint unsigned PHASE_END = 64'd1024 << 16;
   localparam logic [INC_W-1:0] INC_LIMIT = '1;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;
   // Function codes the block does not use.
   localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

   typedef struct packed {
      logic signed [SMP_W-1:0] sample;
      logic                    free;
      logic                    wrapped;
   } osc_output_type;

   typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [FUNC_W-1:0]         req_func = '0;
   logic [ADDR_W-1:0]         req_table_addr = '0;
   logic signed [SMP_W-1:0]   req_table_value = '0;
   logic signed [PITCH_W-1:0] req_pitch_offset = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [SMP_W-1:0]   rsp_sample;
   logic                      rsp_free;
   logic                      rsp_wrapped;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_IX_W-1:0]       csr_index = '0;
   logic [CSR_D_W-1:0]        csr_write_data = '0;

   // Oscillator state as predicted from the transactions accepted so far.
   logic signed [SMP_W-1:0] model_table_a [TABLE_DEPTH];
   logic signed [SMP_W-1:0] model_table_b [TABLE_DEPTH];
   bit                      loaded_a [TABLE_DEPTH];
   bit                      loaded_b [TABLE_DEPTH];
   logic [BASE_W-1:0]       model_base = '0;
   logic [WFRAC_W-1:0]      model_weight = '0;
   logic [NCYC_W-1:0]       model_passes = 16'd1;
   longint unsigned         model_phase = 0;
   logic [INC_W-1:0]        model_step = '0;
   logic [NCYC_W-1:0]       passes_left = 16'd1;
   bit                      free_flag = 1'b0;
   bit                      sounding = 1'b0;

   osc_output_type awaited_outputs [$];
   rx_mode_type    rx_mode = RX_OPEN;
   int unsigned    hold_left = 0;
   int unsigned    transactions_sent = 0;
   int unsigned    ticks_sent = 0;
   int unsigned    mismatches = 0;
   int unsigned    wraps_seen = 0;
   int unsigned    frees_seen = 0;

   crossfade_wavetable_pulse_oscillator_unit #(
      .TABLE_SIZE(TABLE_DEPTH)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_table_addr   (req_table_addr),
      .req_table_value  (req_table_value),
      .req_pitch_offset (req_pitch_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_free         (rsp_free),
      .rsp_wrapped      (rsp_wrapped),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin : clock_gen
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Round half up after a 16-bit fractional product: floor((x + 2^15) / 2^16).
   function automatic longint round_q16(input longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   function automatic longint lerp_entry(input longint v0, input longint v1,
                                         input longint frac);
      return v0 + round_q16((v1 - v0) * frac);
   endfunction

   // Advances the predicted oscillator by one transaction and returns its response.
   function automatic osc_output_type oscillator_step(input logic [FUNC_W-1:0] func,
                                                      input logic [ADDR_W-1:0] addr,
                                                      input logic signed [SMP_W-1:0] value,
                                                      input logic signed [PITCH_W-1:0] pitch);
      osc_output_type  res;
      int unsigned     lo;
      int unsigned     hi;
      longint          frac;
      longint          weight;
      longint          mix_a;
      longint          mix_b;
      longint          mixed;
      longint          ratio;
      longint unsigned next_step;
      res.sample = '0;
      res.wrapped = 1'b0;
      case (func)
         FUNC_TICK: begin
            // Reads past the last entry wrap round to the start of the table.
            lo = 32'((model_phase >> 16) % TABLE_DEPTH);
            hi = (lo + 1) % TABLE_DEPTH;
            frac = model_phase & 64'hFFFF;
            weight = longint'(model_weight);
            if (weight > 65536) weight = 65536;
            mix_a = lerp_entry(model_table_a[lo], model_table_a[hi], frac);
            mix_b = lerp_entry(model_table_b[lo], model_table_b[hi], frac);
            mixed = round_q16(mix_a * (65536 - weight) + mix_b * weight);
            if (mixed > 32767) mixed = 32767;
            if (mixed < -32768) mixed = -32768;
            // The phase moves by the step formed on the previous tick.
            model_phase += 64'(model_step);
            ratio = 16384 + longint'(pitch);
            if (ratio < 0) ratio = 0;
            next_step = 64'(model_base);
            next_step = (next_step * ratio) >> 14;
            model_step = (next_step > INC_LIMIT) ? INC_LIMIT : next_step[INC_W-1:0];
            // A phase exactly at the table end is kept; only beyond it wraps.
            if (model_phase > PHASE_END) begin
               model_phase = 0;
               res.wrapped = 1'b1;
               if (passes_left <= 1) begin
                  free_flag = 1'b1;
                  passes_left = model_passes;
               end else begin
                  passes_left--;
               end
            end
            if (sounding) res.sample = mixed[SMP_W-1:0];
         end
         FUNC_WRITE_A: begin
            model_table_a[addr] = value;
            loaded_a[addr] = 1'b1;
         end
         FUNC_WRITE_B: begin
            model_table_b[addr] = value;
            loaded_b[addr] = 1'b1;
         end
         FUNC_START: begin
            sounding = 1'b1;
            free_flag = 1'b0;
         end
         FUNC_MUTE: sounding = 1'b0;
         FUNC_PHASE_RESET: model_phase = 0;
         default: ;
      endcase
      res.free = free_flag;
      return res;
   endfunction

   // Offers one transaction, waits for it to be taken and records its response.
   task automatic send_transaction(input logic [FUNC_W-1:0] func,
                                   input logic [ADDR_W-1:0] addr,
                                   input logic signed [SMP_W-1:0] value,
                                   input logic signed [PITCH_W-1:0] pitch);
      @(negedge clock);
      req_valid <= 1'b1;
      req_func <= func;
      req_table_addr <= addr;
      req_table_value <= value;
      req_pitch_offset <= pitch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_outputs.push_back(oscillator_step(func, addr, value, pitch));
      transactions_sent++;
      if (func == FUNC_TICK) ticks_sent++;
   endtask

   // Sends a tick, first loading any entry it would read that was never written.
   task automatic send_tick(input logic signed [PITCH_W-1:0] pitch);
      int unsigned lo;
      int unsigned hi;
      lo = 32'((model_phase >> 16) % TABLE_DEPTH);
      hi = (lo + 1) % TABLE_DEPTH;
      if (!loaded_a[lo])
         send_transaction(FUNC_WRITE_A, lo[ADDR_W-1:0], SMP_W'($urandom), '0);
      if (!loaded_a[hi])
         send_transaction(FUNC_WRITE_A, hi[ADDR_W-1:0], SMP_W'($urandom), '0);
      if (!loaded_b[lo])
         send_transaction(FUNC_WRITE_B, lo[ADDR_W-1:0], SMP_W'($urandom), '0);
      if (!loaded_b[hi])
         send_transaction(FUNC_WRITE_B, hi[ADDR_W-1:0], SMP_W'($urandom), '0);
      send_transaction(FUNC_TICK, ADDR_W'($urandom), SMP_W'($urandom), pitch);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic wait_for_outputs();
      pause_sender(1);
      while (awaited_outputs.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index, input logic [CSR_D_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      case (index)
         CSR_BASE_INCREMENT: model_base = data[BASE_W-1:0];
         CSR_WAVE_FRACTION:  model_weight = data[WFRAC_W-1:0];
         CSR_NUM_CYCLES: begin
            model_passes = data[NCYC_W-1:0];
            passes_left = model_passes;
         end
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Registers change only once the block has returned every response.
   task automatic configure(input logic [BASE_W-1:0] base, input logic [WFRAC_W-1:0] weight,
                            input logic [NCYC_W-1:0] passes);
      wait_for_outputs();
      write_register(CSR_BASE_INCREMENT, CSR_D_W'(base));
      write_register(CSR_WAVE_FRACTION, CSR_D_W'(weight));
      write_register(CSR_NUM_CYCLES, CSR_D_W'(passes));
   endtask

   // Random traffic dominated by ticks, with table loads and control transactions.
   task automatic run_random_items(input int unsigned count, input bit with_gaps);
      int unsigned               target;
      int unsigned               burst_left;
      int unsigned               pick;
      logic [FUNC_W-1:0]         func;
      logic signed [PITCH_W-1:0] pitch;
      target = transactions_sent + count;
      burst_left = $urandom_range(1, 40);
      while (transactions_sent < target) begin
         pick = $urandom_range(0, 99);
         // Pitch is near unity, across the nominal range or anywhere, in equal shares.
         case ($urandom_range(0, 2))
            0:       pitch = PITCH_W'($urandom_range(0, 4095) - 2048);
            1:       pitch = PITCH_W'($urandom_range(0, 65535) - 16384);
            default: pitch = PITCH_W'($urandom);
         endcase
         if (pick < 55) begin
            send_tick(pitch);
         end else begin
            if (pick < 70) func = FUNC_WRITE_A;
            else if (pick < 85) func = FUNC_WRITE_B;
            else if (pick < 91) func = FUNC_START;
            else if (pick < 95) func = FUNC_MUTE;
            else if (pick < 98) func = FUNC_PHASE_RESET;
            else if (pick == 98) func = FUNC_SPARE_A;
            else func = FUNC_SPARE_B;
            send_transaction(func, ADDR_W'($urandom), SMP_W'($urandom), pitch);
         end
         if (with_gaps) begin
            burst_left--;
            if (burst_left == 0) begin
               pause_sender($urandom_range(1, 12));
               burst_left = $urandom_range(1, 40);
            end
         end
      end
   endtask

   // Table extremes, silent and muted ticks, the phase landing on the table end,
   // reads past the end, clamped and saturated steps, zero pass count, spare codes.
   task automatic test_directed_cases();
      configure(27'h4000000, 17'd32768, 16'd2);
      send_transaction(FUNC_WRITE_A, 10'd0, 16'sh7FFF, '0);
      send_transaction(FUNC_WRITE_A, 10'd1, 16'sh8000, '0);
      send_transaction(FUNC_WRITE_B, 10'd0, 16'sh8000, '0);
      send_transaction(FUNC_WRITE_B, 10'd1, 16'sh7FFF, '0);
      send_transaction(FUNC_WRITE_A, 10'd1023, 16'shFFFF, '0);
      send_transaction(FUNC_WRITE_B, 10'd1023, 16'sh0001, '0);
      send_tick('0);
      send_transaction(FUNC_START, '0, '0, '0);
      send_tick('0);
      send_tick('0);
      // Most negative offset: the ratio is clamped to zero.
      send_tick(17'sh10000);
      send_transaction(FUNC_MUTE, '0, '0, '0);
      send_tick(17'sd16384);
      send_tick('0);
      // Largest base and offset saturate the step; a zero pass count frees on every wrap.
      configure(27'h7FFFFFF, 17'h10000, 16'd0);
      send_transaction(FUNC_START, '0, '0, '0);
      send_transaction(FUNC_PHASE_RESET, '0, '0, '0);
      send_tick(17'shFFFF);
      send_tick('0);
      send_transaction(FUNC_SPARE_A, 10'h3FF, 16'shFFFF, 17'h1FFFF);
      send_transaction(FUNC_SPARE_B, 10'h3FF, 16'shFFFF, 17'h1FFFF);
   endtask

   task automatic test_register_settings();
      configure(27'd0, 17'd0, 16'd1);
      rx_mode = RX_LIGHT;
      run_random_items(120, 1'b1);
      configure(27'h4000000, 17'h10000, 16'd0);
      rx_mode = RX_HEAVY;
      run_random_items(150, 1'b1);
      configure(27'h7FFFFFF, 17'h1FFFF, 16'hFFFF);
      rx_mode = RX_OPEN;
      run_random_items(150, 1'b0);
      repeat (6) begin
         configure(BASE_W'($urandom_range(4096, 27'h4000000) >> $urandom_range(0, 6)),
                   WFRAC_W'($urandom_range(0, 65536)),
                   NCYC_W'($urandom_range(1, 4)));
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         run_random_items(180, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_backpressure();
      configure(27'h1000000, 17'd20000, 16'd3);
      rx_mode = RX_OPEN;
      // Hold the response side off long enough for the block to stall its input.
      hold_left = HOLD_OFF_CYCLES;
      run_random_items(150, 1'b0);
      wait_for_outputs();
      rx_mode = RX_LIGHT;
      run_random_items(100, 1'b0);
   endtask

   // Response stalls come in runs; a requested hold-off overrides them.
   initial begin : receiver
      int unsigned run_left;
      run_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (run_left != 0) begin
            run_left--;
         end else begin
            case (rx_mode)
               RX_OPEN:  rsp_stall <= 1'b0;
               RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               default:  rsp_stall <= ($urandom_range(0, 1) == 0);
            endcase
            run_left = (rx_mode == RX_HEAVY) ? $urandom_range(0, 15) : $urandom_range(0, 5);
         end
      end
   end

   // Each accepted response is compared with the oldest awaited one.
   always @(posedge clock) begin : check_outputs
      osc_output_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_outputs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected response: sample %0d free %0b wrapped %0b",
                        $time, rsp_sample, rsp_free, rsp_wrapped);
         end else begin
            want = awaited_outputs.pop_front();
            if (rsp_sample !== want.sample || rsp_free !== want.free ||
                rsp_wrapped !== want.wrapped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: mismatch: sample %0d/%0d free %0b/%0b wrapped %0b/%0b %s",
                           $time, want.sample, rsp_sample, want.free, rsp_free,
                           want.wrapped, rsp_wrapped, "(expected/actual)");
            end
            if (rsp_wrapped === 1'b1) wraps_seen++;
            if (rsp_free === 1'b1) frees_seen++;
         end
      end
   end

   // Ends the run when no transaction has moved on any port for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             csr_write_enable)
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: nothing moved for %0d cycles, %0d responses outstanding.",
               quiet, awaited_outputs.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_register_settings();
      test_backpressure();
      wait_for_outputs();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d transactions (%0d ticks); saw %0d wraps, %0d free responses, %0d errors.",
               transactions_sent, ticks_sent, wraps_seen, frees_seen, mismatches);
      $display("Registers swept over zero, full-scale and random values with stalls on both sides.");
      if (mismatches == 0 && awaited_outputs.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
